FILE: design/twg_pkg.sv
`timescale 1ns / 1ps

package twg_pkg;

    // Geometry of the bit-sliced state and of the result words.
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 6;
    localparam int IDX_W     = 3;
    localparam int MOD_W     = 31;

    // The remainder unit retires one dividend bit per cycle.
    localparam int REM_STEPS = WORD_W;
    localparam int CNT_W     = 6;

    // Tap distances and feedback placement of the three registers.
    localparam int SH_A_OUT  = 93 - 66;
    localparam int SH_A_FB   = 93 - 69;
    localparam int SH_B_OUT  = 177 - 162;
    localparam int SH_B_FB   = 177 - 171;
    localparam int SH_C_OUT  = 288 - 243;
    localparam int SH_C_FB   = 288 - 264;
    localparam int INS_A     = 29;
    localparam int INS_B     = 20;
    localparam int INS_C     = 47;

    typedef enum logic [1:0] {
        CMD_SEED = 2'd0,
        CMD_INIT = 2'd1,
        CMD_GEN  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic capture;
        logic seed_en;
        logic round_en;
        logic rem_start;
        logic rem_step;
        logic rem_last;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_zero;
    } dp_stat_t;

endpackage

FILE: design/twg_ctrl.sv
`timescale 1ns / 1ps

module twg_ctrl #(
    parameter int WARMUP_ROUNDS = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  twg_pkg::cmd_t       cmd,
    output logic                busy,
    output logic                done,
    output logic                not_ready,
    output twg_pkg::dp_cmd_t    dp_cmd,
    input  twg_pkg::dp_stat_t   dp_stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WARM,
        ST_ROUND,
        ST_REM,
        ST_FIN
    } state_t;

    localparam logic [twg_pkg::CNT_W-1:0] WARM_LAST =
        twg_pkg::CNT_W'(WARMUP_ROUNDS - 1);
    localparam logic [twg_pkg::CNT_W-1:0] REM_LAST =
        twg_pkg::CNT_W'(twg_pkg::REM_STEPS - 1);

    state_t                     state_reg, state_next;
    logic [twg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       ready_reg, ready_next;
    logic                       done_reg, done_next;
    logic                       not_ready_reg, not_ready_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ready_next     = ready_reg;
        not_ready_next = not_ready_reg;
        dp_cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.capture = 1'b1;
                    not_ready_next = 1'b0;
                    cnt_next       = '0;
                    unique case (cmd)
                        twg_pkg::CMD_SEED:
                        begin
                            dp_cmd.seed_en = 1'b1;
                            state_next     = ST_FIN;
                        end
                        twg_pkg::CMD_INIT:
                        begin
                            state_next = ST_WARM;
                        end
                        twg_pkg::CMD_GEN:
                        begin
                            if (ready_reg)
                            begin
                                state_next = ST_ROUND;
                            end
                            else
                            begin
                                not_ready_next = 1'b1;
                                state_next     = ST_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_WARM:
            begin
                dp_cmd.round_en = 1'b1;
                if (cnt_reg == WARM_LAST)
                begin
                    ready_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                dp_cmd.round_en  = 1'b1;
                dp_cmd.rem_start = 1'b1;
                cnt_next         = '0;
                state_next       = dp_stat.mod_zero ? ST_FIN : ST_REM;
            end
            ST_REM:
            begin
                dp_cmd.rem_step = 1'b1;
                if (cnt_reg == REM_LAST)
                begin
                    dp_cmd.rem_last = 1'b1;
                    state_next      = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = (state_next == ST_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            done_reg      <= 1'b0;
            not_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            done_reg      <= done_next;
            not_ready_reg <= not_ready_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign not_ready = not_ready_reg;

endmodule

FILE: design/twg_datapath.sv
`timescale 1ns / 1ps

module twg_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  twg_pkg::dp_cmd_t                  dp_cmd,
    output twg_pkg::dp_stat_t                 dp_stat,
    input  logic [twg_pkg::IDX_W-1:0]         word_index,
    input  logic [twg_pkg::WORD_W-1:0]        seed_word,
    input  logic [twg_pkg::MOD_W-1:0]         modulus,
    output logic [twg_pkg::WORD_W-1:0]        random_word,
    output logic [twg_pkg::WORD_W-1:0]        reduced_value
);

    localparam int W = twg_pkg::WORD_W;
    localparam int M = twg_pkg::MOD_W;

    // Low 64 bits of the concatenation {lo, hi} shifted right by k.
    function automatic logic [W-1:0] pair_shift(
        input logic [W-1:0] lo,
        input logic [W-1:0] hi,
        input int           k
    );
        logic [2*W-1:0] cat;
        cat = {lo, hi} >> k;
        return cat[W-1:0];
    endfunction

    logic [W-1:0] words_reg [twg_pkg::NUM_WORDS];
    logic [W-1:0] words_next [twg_pkg::NUM_WORDS];
    logic [W-1:0] t1, t2, t3, z;
    logic [W-1:0] t1f, t2f, t3f;

    logic [M-1:0] mod_reg;
    logic [M-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg;
    logic [M:0]   rem_shift;
    logic [M:0]   rem_diff;
    logic [W-1:0] random_word_reg;
    logic [W-1:0] reduced_value_reg;

    // One round advances all three registers by a full word of steps.
    always_comb
    begin
        t1 = words_reg[1] ^ pair_shift(words_reg[0], words_reg[1], twg_pkg::SH_A_OUT);
        t2 = words_reg[3] ^ pair_shift(words_reg[2], words_reg[3], twg_pkg::SH_B_OUT);
        t3 = pair_shift(words_reg[4], words_reg[5], twg_pkg::SH_C_OUT) ^ words_reg[5];
        z  = t1 ^ t2 ^ t3;

        t1f = t1 ^ (pair_shift(words_reg[0], words_reg[1], 1)
                    & pair_shift(words_reg[0], words_reg[1], 2))
                 ^ pair_shift(words_reg[2], words_reg[3], twg_pkg::SH_B_FB);
        t2f = t2 ^ (pair_shift(words_reg[2], words_reg[3], 1)
                    & pair_shift(words_reg[2], words_reg[3], 2))
                 ^ pair_shift(words_reg[4], words_reg[5], twg_pkg::SH_C_FB);
        t3f = t3 ^ (pair_shift(words_reg[4], words_reg[5], 1)
                    & pair_shift(words_reg[4], words_reg[5], 2))
                 ^ pair_shift(words_reg[0], words_reg[1], twg_pkg::SH_A_FB);

        words_next[1] = (t3f << twg_pkg::INS_A) | words_reg[0];
        words_next[0] = t3f >> (W - twg_pkg::INS_A);
        words_next[3] = (t1f << twg_pkg::INS_B) | words_reg[2];
        words_next[2] = t1f >> (W - twg_pkg::INS_B);
        words_next[5] = (t2f << twg_pkg::INS_C) | words_reg[4];
        words_next[4] = t2f >> (W - twg_pkg::INS_C);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < twg_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (dp_cmd.round_en)
        begin
            for (int i = 0; i < twg_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= words_next[i];
            end
        end
        else if (dp_cmd.seed_en)
        begin
            for (int i = 0; i < twg_pkg::NUM_WORDS; i++)
            begin
                if (word_index == twg_pkg::IDX_W'(i))
                begin
                    words_reg[i] <= words_reg[i] ^ seed_word;
                end
            end
        end
    end

    // Restoring remainder, one dividend bit per cycle, MSB first.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        rem_diff  = rem_shift - {1'b0, mod_reg};
        if (rem_shift >= {1'b0, mod_reg})
        begin
            rem_next = rem_diff[M-1:0];
        end
        else
        begin
            rem_next = rem_shift[M-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            mod_reg           <= modulus;
            random_word_reg   <= '0;
            reduced_value_reg <= '0;
        end
        if (dp_cmd.rem_start)
        begin
            random_word_reg   <= z;
            reduced_value_reg <= z;
            rem_reg           <= '0;
            quo_reg           <= z;
        end
        if (dp_cmd.rem_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_reg << 1;
        end
        if (dp_cmd.rem_last)
        begin
            reduced_value_reg <= {{(W - M){1'b0}}, rem_next};
        end
    end

    assign dp_stat.mod_zero = (mod_reg == '0);
    assign random_word      = random_word_reg;
    assign reduced_value    = reduced_value_reg;

endmodule

FILE: design/trivium_word_generator_top.sv
`timescale 1ns / 1ps
// Seed, no-op and a generate refused as not ready go straight to the finish state;
// init runs WARMUP_ROUNDS warm-up rounds, generate with modulus 0 one round, and
// generate with a modulus one round, then one remainder step per bit of the word.
// One transaction at a time: the next start is taken the cycle after done.
// The result holds until the next start is accepted; the receiver cannot stall it.
// Reset clears the state words, the ready flag and the controller.

module trivium_word_generator_top #(
    parameter int WARMUP_ROUNDS = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    cmd,
    input  logic [twg_pkg::IDX_W-1:0]     word_index,
    input  logic [twg_pkg::WORD_W-1:0]    seed_word,
    input  logic [twg_pkg::MOD_W-1:0]     modulus,
    output logic                          done,
    output logic [twg_pkg::WORD_W-1:0]    random_word,
    output logic [twg_pkg::WORD_W-1:0]    reduced_value,
    output logic                          not_ready
);

    // The controller sequences each transaction: it counts the warm-up rounds,
    // owns the ready flag and the strobe, and steps the remainder unit. The
    // datapath holds the six state words, the round logic, and the iterative
    // remainder of the keystream word by the captured modulus.
    twg_pkg::dp_cmd_t  dp_cmd;
    twg_pkg::dp_stat_t dp_stat;

    twg_ctrl #(
        .WARMUP_ROUNDS (WARMUP_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (twg_pkg::cmd_t'(cmd)),
        .busy      (busy),
        .done      (done),
        .not_ready (not_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    // Result fields are cleared when a transaction is accepted, so every
    // command other than a completed generate reports all zeros.
    twg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .word_index    (word_index),
        .seed_word     (seed_word),
        .modulus       (modulus),
        .random_word   (random_word),
        .reduced_value (reduced_value)
    );

endmodule
